[rtl/page_table_walker_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the page table walker checker.
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALKER_MACROS_SVH
`define PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptw_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and the microcode ROM of the page table walker.
// ---------------------------------------------------------------------------
package ptw_pkg;

    localparam int TABLE_FRAMES_DEF  = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int PAGE_SHIFT        = 12;
    localparam int FRAME_ADDR_W      = 40;
    localparam int ENTRY_W           = 52;
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int FLAG_W            = 12;
    localparam int VPN_W             = VA_W - PAGE_SHIFT;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_USER    = 2;

    // Opcodes
    localparam logic [1:0] OP_XLATE = 2'd0;
    localparam logic [1:0] OP_MAP   = 2'd1;
    localparam logic [1:0] OP_UNMAP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [1:0] ST_NO_TABLES  = 2'd2;

    // Datapath actions
    typedef logic [3:0] ptw_act_t;
    localparam ptw_act_t A_NOP        = 4'd0;
    localparam ptw_act_t A_CLEAR      = 4'd1;
    localparam ptw_act_t A_ACCEPT     = 4'd2;
    localparam ptw_act_t A_READ       = 4'd3;
    localparam ptw_act_t A_DESCEND    = 4'd4;
    localparam ptw_act_t A_SET_USER   = 4'd5;
    localparam ptw_act_t A_ALLOC      = 4'd6;
    localparam ptw_act_t A_WRITE_LEAF = 4'd7;
    localparam ptw_act_t A_CLEAR_LEAF = 4'd8;
    localparam ptw_act_t A_XLATE_HIT  = 4'd9;
    localparam ptw_act_t A_NOT_MAPPED = 4'd10;
    localparam ptw_act_t A_NO_TABLES  = 4'd11;
    localparam ptw_act_t A_EMIT       = 4'd12;

    // Branch conditions
    typedef logic [3:0] ptw_cond_t;
    localparam ptw_cond_t C_NONE       = 4'd0;
    localparam ptw_cond_t C_ALWAYS     = 4'd1;
    localparam ptw_cond_t C_CLR_LAST   = 4'd2;
    localparam ptw_cond_t C_IN_VALID   = 4'd3;
    localparam ptw_cond_t C_OUT_FREE   = 4'd4;
    localparam ptw_cond_t C_OP_XLATE   = 4'd5;
    localparam ptw_cond_t C_OP_MAP     = 4'd6;
    localparam ptw_cond_t C_OP_UNMAP   = 4'd7;
    localparam ptw_cond_t C_PRESENT    = 4'd8;
    localparam ptw_cond_t C_ENTRY_OK   = 4'd9;
    localparam ptw_cond_t C_LAST_UPPER = 4'd10;
    localparam ptw_cond_t C_ALLOC_FULL = 4'd11;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] ptw_pc_t;

    // Program labels
    localparam ptw_pc_t S_CLR      = 5'd0;
    localparam ptw_pc_t S_IDLE     = 5'd1;
    localparam ptw_pc_t S_DISP     = 5'd2;
    localparam ptw_pc_t S_DISP_UN  = 5'd3;
    localparam ptw_pc_t S_DISP_XL  = 5'd4;
    localparam ptw_pc_t S_WALK_RD  = 5'd5;
    localparam ptw_pc_t S_WALK_CHK = 5'd6;
    localparam ptw_pc_t S_WALK_DSC = 5'd7;
    localparam ptw_pc_t S_WALK_END = 5'd8;
    localparam ptw_pc_t S_XL_RD    = 5'd9;
    localparam ptw_pc_t S_XL_CHK   = 5'd10;
    localparam ptw_pc_t S_XL_HIT   = 5'd11;
    localparam ptw_pc_t S_UNMAP    = 5'd12;
    localparam ptw_pc_t S_MISS     = 5'd13;
    localparam ptw_pc_t S_MAP_RD   = 5'd14;
    localparam ptw_pc_t S_MAP_CHK  = 5'd15;
    localparam ptw_pc_t S_MAP_USR  = 5'd16;
    localparam ptw_pc_t S_MAP_DSC  = 5'd17;
    localparam ptw_pc_t S_MAP_LEAF = 5'd18;
    localparam ptw_pc_t S_MAP_NEW  = 5'd19;
    localparam ptw_pc_t S_MAP_ALC  = 5'd20;
    localparam ptw_pc_t S_MAP_NXT  = 5'd21;
    localparam ptw_pc_t S_NO_TAB   = 5'd22;
    localparam ptw_pc_t S_EMIT     = 5'd23;
    localparam ptw_pc_t S_RETURN   = 5'd24;

    // One control word: an action, and a branch taken when cond ^ inv holds
    typedef struct packed {
        ptw_act_t  action;
        ptw_cond_t cond;
        logic      inv;
        ptw_pc_t   target;
    } ptw_uop_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic clr_last;
        logic op_xlate;
        logic op_map;
        logic op_unmap;
        logic present;
        logic entry_ok;
        logic last_upper;
        logic alloc_full;
    } ptw_flags_t;

    function automatic ptw_uop_t mk_uop(ptw_act_t a, ptw_cond_t c, logic i, ptw_pc_t t);
        ptw_uop_t u;
        u.action = a;
        u.cond   = c;
        u.inv    = i;
        u.target = t;
        return u;
    endfunction

    function automatic ptw_uop_t ucode(ptw_pc_t pc);
        ptw_uop_t u;
        case (pc)
            S_CLR:      u = mk_uop(A_CLEAR,      C_CLR_LAST,   1'b1, S_CLR);
            S_IDLE:     u = mk_uop(A_ACCEPT,     C_IN_VALID,   1'b1, S_IDLE);
            S_DISP:     u = mk_uop(A_NOP,        C_OP_MAP,     1'b0, S_MAP_RD);
            S_DISP_UN:  u = mk_uop(A_NOP,        C_OP_UNMAP,   1'b0, S_WALK_RD);
            S_DISP_XL:  u = mk_uop(A_NOP,        C_OP_XLATE,   1'b1, S_EMIT);
            S_WALK_RD:  u = mk_uop(A_READ,       C_NONE,       1'b0, S_WALK_RD);
            S_WALK_CHK: u = mk_uop(A_NOP,        C_ENTRY_OK,   1'b1, S_MISS);
            S_WALK_DSC: u = mk_uop(A_DESCEND,    C_LAST_UPPER, 1'b1, S_WALK_RD);
            S_WALK_END: u = mk_uop(A_NOP,        C_OP_UNMAP,   1'b0, S_UNMAP);
            S_XL_RD:    u = mk_uop(A_READ,       C_NONE,       1'b0, S_XL_RD);
            S_XL_CHK:   u = mk_uop(A_NOP,        C_PRESENT,    1'b1, S_MISS);
            S_XL_HIT:   u = mk_uop(A_XLATE_HIT,  C_ALWAYS,     1'b0, S_EMIT);
            S_UNMAP:    u = mk_uop(A_CLEAR_LEAF, C_ALWAYS,     1'b0, S_EMIT);
            S_MISS:     u = mk_uop(A_NOT_MAPPED, C_ALWAYS,     1'b0, S_EMIT);
            S_MAP_RD:   u = mk_uop(A_READ,       C_NONE,       1'b0, S_MAP_RD);
            S_MAP_CHK:  u = mk_uop(A_NOP,        C_PRESENT,    1'b1, S_MAP_NEW);
            S_MAP_USR:  u = mk_uop(A_SET_USER,   C_ENTRY_OK,   1'b1, S_MISS);
            S_MAP_DSC:  u = mk_uop(A_DESCEND,    C_LAST_UPPER, 1'b1, S_MAP_RD);
            S_MAP_LEAF: u = mk_uop(A_WRITE_LEAF, C_ALWAYS,     1'b0, S_EMIT);
            S_MAP_NEW:  u = mk_uop(A_NOP,        C_ALLOC_FULL, 1'b0, S_NO_TAB);
            S_MAP_ALC:  u = mk_uop(A_ALLOC,      C_LAST_UPPER, 1'b0, S_MAP_LEAF);
            S_MAP_NXT:  u = mk_uop(A_NOP,        C_ALWAYS,     1'b0, S_MAP_RD);
            S_NO_TAB:   u = mk_uop(A_NO_TABLES,  C_ALWAYS,     1'b0, S_EMIT);
            S_EMIT:     u = mk_uop(A_EMIT,       C_OUT_FREE,   1'b1, S_EMIT);
            S_RETURN:   u = mk_uop(A_NOP,        C_ALWAYS,     1'b0, S_IDLE);
            default:    u = mk_uop(A_NOP,        C_ALWAYS,     1'b0, S_IDLE);
        endcase
        return u;
    endfunction

endpackage

[rtl/ptw_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptw_store
// Single-port table store with registered read data.
// ---------------------------------------------------------------------------
module ptw_store
    import ptw_pkg::*;
#(
    parameter int DEPTH = TABLE_FRAMES_DEF * ENTRIES_PER_TABLE
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [ENTRY_W-1:0]       wdata,
    output logic [ENTRY_W-1:0]       rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ptw_useq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptw_useq
// Microcode sequencer: step counter, control ROM and conditional branch.
// ---------------------------------------------------------------------------
module ptw_useq
    import ptw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ptw_flags_t flags,
    input  logic       in_valid,
    input  logic       out_free,
    output ptw_uop_t   uop
);

    ptw_pc_t pc_reg;
    ptw_pc_t pc_next;
    logic    cond_val;

    assign uop = ucode(pc_reg);

    always_comb
    begin
        case (uop.cond)
            C_NONE:       cond_val = 1'b0;
            C_ALWAYS:     cond_val = 1'b1;
            C_CLR_LAST:   cond_val = flags.clr_last;
            C_IN_VALID:   cond_val = in_valid;
            C_OUT_FREE:   cond_val = out_free;
            C_OP_XLATE:   cond_val = flags.op_xlate;
            C_OP_MAP:     cond_val = flags.op_map;
            C_OP_UNMAP:   cond_val = flags.op_unmap;
            C_PRESENT:    cond_val = flags.present;
            C_ENTRY_OK:   cond_val = flags.entry_ok;
            C_LAST_UPPER: cond_val = flags.last_upper;
            C_ALLOC_FULL: cond_val = flags.alloc_full;
            default:      cond_val = 1'b0;
        endcase
    end

    // Branch on cond ^ inv, else advance one step
    assign pc_next = (cond_val ^ uop.inv) ? uop.target : pc_reg + ptw_pc_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_CLR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/ptw_dpath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptw_dpath
// Walk datapath: request registers, frame and level, allocator, base
// register, store address and write data, and the result fields.
// ---------------------------------------------------------------------------
module ptw_dpath
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptw_uop_t                            uop,
    input  logic                                in_valid,
    input  logic [1:0]                          opcode,
    input  logic [VA_W-1:0]                     virt_addr,
    input  logic [PA_W-1:0]                     phys_addr,
    input  logic [FLAG_W-1:0]                   flags,
    input  logic                                cfg_wr_en,
    input  logic [FRAME_ADDR_W-1:0]             cfg_wr_data,
    output logic                                mem_we,
    output logic                                mem_re,
    output logic [$clog2(TABLE_FRAMES)+IDX_W-1:0] mem_addr,
    output logic [ENTRY_W-1:0]                  mem_wdata,
    input  logic [ENTRY_W-1:0]                  mem_rdata,
    output ptw_flags_t                          dp_flags,
    output logic [1:0]                          res_status,
    output logic [PA_W-1:0]                     res_phys,
    output logic                                res_inv,
    output logic [VA_W-1:0]                     res_inv_page
);

    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int NFW   = $clog2(TABLE_FRAMES + 1);
    localparam int AW    = FW + IDX_W;
    localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;

    // Control state
    logic [AW-1:0]           clr_cnt_reg,   clr_cnt_next;
    logic [NFW-1:0]          next_free_reg, next_free_next;
    logic [FRAME_ADDR_W-1:0] base_reg,      base_next;
    logic [1:0]              level_reg,     level_next;
    logic [FW-1:0]           frame_reg,     frame_next;

    // Request and result payload
    logic [1:0]              opcode_reg,    opcode_next;
    logic [VPN_W-1:0]        vpn_reg,       vpn_next;
    logic [FRAME_ADDR_W-1:0] pfn_reg,       pfn_next;
    logic [FLAG_W-1:0]       flags_reg,     flags_next;
    logic [1:0]              status_reg,    status_next;
    logic [FRAME_ADDR_W-1:0] phys_reg,      phys_next;
    logic                    inv_reg,       inv_next;

    logic [IDX_W-1:0]        idx;
    logic [FRAME_ADDR_W-1:0] local_frame;
    logic [FRAME_ADDR_W-1:0] alloc_pfn;
    logic                    user_req;
    logic                    accept;

    assign accept   = (uop.action == A_ACCEPT) && in_valid;
    assign user_req = flags_reg[BIT_USER];

    // Table index for the current level
    always_comb
    begin
        case (level_reg)
            2'd0:    idx = vpn_reg[4*IDX_W-1:3*IDX_W];
            2'd1:    idx = vpn_reg[3*IDX_W-1:2*IDX_W];
            2'd2:    idx = vpn_reg[2*IDX_W-1:IDX_W];
            default: idx = vpn_reg[IDX_W-1:0];
        endcase
    end

    assign local_frame = mem_rdata[ENTRY_W-1:PAGE_SHIFT] - base_reg;
    assign alloc_pfn   = base_reg + FRAME_ADDR_W'(next_free_reg);

    assign dp_flags.clr_last   = (clr_cnt_reg == AW'(DEPTH - 1));
    assign dp_flags.op_xlate   = (opcode_reg == OP_XLATE);
    assign dp_flags.op_map     = (opcode_reg == OP_MAP);
    assign dp_flags.op_unmap   = (opcode_reg == OP_UNMAP);
    assign dp_flags.present    = mem_rdata[BIT_PRESENT];
    assign dp_flags.entry_ok   = mem_rdata[BIT_PRESENT]
                                 && (local_frame < FRAME_ADDR_W'(TABLE_FRAMES));
    assign dp_flags.last_upper = (level_reg == 2'd2);
    assign dp_flags.alloc_full = (next_free_reg >= NFW'(TABLE_FRAMES));

    // Store port
    assign mem_re   = (uop.action == A_READ);
    assign mem_addr = (uop.action == A_CLEAR) ? clr_cnt_reg : {frame_reg, idx};

    always_comb
    begin
        mem_we = (uop.action inside {A_CLEAR, A_ALLOC, A_WRITE_LEAF, A_CLEAR_LEAF})
                 || ((uop.action == A_SET_USER) && user_req);
        case (uop.action)
            A_SET_USER:   mem_wdata = mem_rdata | (ENTRY_W'(1) << BIT_USER);
            A_ALLOC:      mem_wdata = {alloc_pfn, 9'd0, user_req, 2'b11};
            A_WRITE_LEAF: mem_wdata = {pfn_reg, flags_reg[FLAG_W-1:1], 1'b1};
            default:      mem_wdata = '0;
        endcase
    end

    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        next_free_next = next_free_reg;
        base_next      = cfg_wr_en ? cfg_wr_data : base_reg;
        level_next     = level_reg;
        frame_next     = frame_reg;
        opcode_next    = opcode_reg;
        vpn_next       = vpn_reg;
        pfn_next       = pfn_reg;
        flags_next     = flags_reg;
        status_next    = status_reg;
        phys_next      = phys_reg;
        inv_next       = inv_reg;
        case (uop.action)
            A_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            A_ACCEPT:
            begin
                if (accept)
                begin
                    level_next  = 2'd0;
                    frame_next  = '0;
                    opcode_next = opcode;
                    vpn_next    = virt_addr[VA_W-1:PAGE_SHIFT];
                    pfn_next    = phys_addr[PA_W-1:PAGE_SHIFT];
                    flags_next  = flags;
                    status_next = ST_OK;
                    phys_next   = '0;
                    inv_next    = 1'b0;
                end
            end
            A_DESCEND:
            begin
                frame_next = local_frame[FW-1:0];
                level_next = level_reg + 2'd1;
            end
            A_ALLOC:
            begin
                frame_next     = next_free_reg[FW-1:0];
                next_free_next = next_free_reg + NFW'(1);
                level_next     = level_reg + 2'd1;
            end
            A_WRITE_LEAF, A_CLEAR_LEAF:
            begin
                inv_next = 1'b1;
            end
            A_XLATE_HIT:
            begin
                phys_next = mem_rdata[ENTRY_W-1:PAGE_SHIFT];
            end
            A_NOT_MAPPED:
            begin
                status_next = ST_NOT_MAPPED;
            end
            A_NO_TABLES:
            begin
                status_next = ST_NO_TABLES;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            next_free_reg <= NFW'(1);
            base_reg      <= '0;
            level_reg     <= 2'd0;
            frame_reg     <= '0;
            opcode_reg    <= OP_XLATE;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            next_free_reg <= next_free_next;
            base_reg      <= base_next;
            level_reg     <= level_next;
            frame_reg     <= frame_next;
            opcode_reg    <= opcode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vpn_reg    <= vpn_next;
        pfn_reg    <= pfn_next;
        flags_reg  <= flags_next;
        status_reg <= status_next;
        phys_reg   <= phys_next;
        inv_reg    <= inv_next;
    end

    assign res_status   = status_reg;
    assign res_phys     = {phys_reg, 12'd0};
    assign res_inv      = inv_reg;
    assign res_inv_page = inv_reg ? {vpn_reg, 12'd0} : '0;

endmodule

[rtl/page_table_walker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_table_walker
// Four-level page table engine: translate, map and unmap over an internal
// table store, driven by a microcoded sequencer.
// ---------------------------------------------------------------------------
// After reset the block sweeps the table store to zero, one entry a cycle;
// no item is accepted until the sweep ends, while writes to the base
// register through cfg_wr_data are taken at any time. Items then go one at
// a time; the unused opcode goes straight to the result. Each walk follows
// the chain of dependent table reads through the one store port: each of
// the three upper levels takes a read, a check and a descend step of the
// control program. Map adds a user upgrade step on an existing table; a
// level that needs a new table takes a read, a check, an allocator test and
// the allocate step, plus a restart step above the last upper level.
// Results leave through an output register, so the next item is taken
// while a result still waits.
// ---------------------------------------------------------------------------
module page_table_walker
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [FRAME_ADDR_W-1:0] cfg_wr_data,
    // request channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              opcode,
    input  logic [VA_W-1:0]         virt_addr,
    input  logic [PA_W-1:0]         phys_addr,
    input  logic [FLAG_W-1:0]       flags,
    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic [PA_W-1:0]         phys_out,
    output logic                    invalidate,
    output logic [VA_W-1:0]         invalidate_page
);

    localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int AW    = $clog2(DEPTH);

    ptw_uop_t           uop;
    ptw_flags_t         dp_flags;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    logic [1:0]         res_status;
    logic [PA_W-1:0]    res_phys;
    logic               res_inv;
    logic [VA_W-1:0]    res_inv_page;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg;
    logic [PA_W-1:0]    phys_out_reg;
    logic               inv_reg;
    logic [VA_W-1:0]    inv_page_reg;
    logic               out_free;
    logic               out_load;

    // Take an item only in the accept step of the program
    assign in_stall = (uop.action != A_ACCEPT);

    // The output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (uop.action == A_EMIT) && out_free;

    ptw_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (dp_flags),
        .in_valid (in_valid),
        .out_free (out_free),
        .uop      (uop)
    );

    ptw_dpath #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .uop          (uop),
        .in_valid     (in_valid),
        .opcode       (opcode),
        .virt_addr    (virt_addr),
        .phys_addr    (phys_addr),
        .flags        (flags),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mem_we       (mem_we),
        .mem_re       (mem_re),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata),
        .dp_flags     (dp_flags),
        .res_status   (res_status),
        .res_phys     (res_phys),
        .res_inv      (res_inv),
        .res_inv_page (res_inv_page)
    );

    ptw_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Hold the result while stalled, drop it once taken
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= res_status;
            phys_out_reg <= res_phys;
            inv_reg      <= res_inv;
            inv_page_reg <= res_inv_page;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign phys_out        = phys_out_reg;
    assign invalidate      = inv_reg;
    assign invalidate_page = inv_page_reg;

endmodule

[rtl/ptw_checker.sv]
`timescale 1ns / 1ps
`include "page_table_walker_macros.svh"
// ---------------------------------------------------------------------------
// ptw_checker
// Port-level checks on the result channel of the page table walker.
// ---------------------------------------------------------------------------
module ptw_checker
    import ptw_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic [PA_W-1:0]   phys_out,
    input logic              invalidate,
    input logic [VA_W-1:0]   invalidate_page
);

    `PTW_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(phys_out) && $stable(invalidate_page),
        "stalled result changed")

    `PTW_ASSERT_IMP(a_fail_clean, out_valid && (status != ST_OK),
        (phys_out == '0) && !invalidate, "failed request carries address or invalidate")

    `PTW_ASSERT_IMP(a_inv_ok, out_valid && invalidate,
        (status == ST_OK) && (phys_out == '0), "invalidate on a failed request or translate")

    `PTW_ASSERT_IMP(a_no_inv_page, out_valid && !invalidate,
        invalidate_page == '0, "flush page given without invalidate")

    `PTW_ASSERT_IMP(a_page_align, out_valid,
        (phys_out[11:0] == 12'd0) && (invalidate_page[11:0] == 12'd0),
        "result address not page aligned")

endmodule

bind page_table_walker ptw_checker u_ptw_checker (.*);
